/* src/sha256_pkg.sv */
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenOffset  = 56;

   typedef logic [31:0] word_type;

   localparam word_type InitialHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte = 8'h80;

   // byte source select for the block buffer write
   typedef enum logic [1:0] {
      SRC_INPUT = 2'd0,
      SRC_PAD   = 2'd1,
      SRC_ZERO  = 2'd2,
      SRC_LEN   = 2'd3
   } byte_src_type;

   // controller to datapath
   typedef struct packed {
      logic         put;          // write one byte into the buffer
      byte_src_type src;
      logic         count_len;    // add eight to the bit length
      logic         latch_len;    // freeze length for the trailer
      logic         comp_start;   // load working vars, start rounds
      logic         comp_step;    // one round
      logic         comp_fold;    // add working vars into chaining value
      logic         out_load;     // latch digest into output shift
      logic         out_shift;    // next digest word
      logic         restart;      // back to initial hash, zero length
      logic         restart_fill; // clear the block full flag
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       block_full; // fill wrapped on the last put
      logic       last_round;
      logic [2:0] len_pos;    // trailer byte position (fill - 56)
   } dp_status_type;

   function automatic word_type rotr(word_type x, int unsigned r);
      return (x >> r) | (x << (32 - r));
   endfunction

endpackage

/* src/sha256_datapath.sv */
module sha256_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::dp_cmd_type    cmd,
   input  logic [7:0]                in_byte,
   output sha256_pkg::dp_status_type status,
   output sha256_pkg::word_type      out_word
);

   // block buffer held as sixteen big-endian words
   sha256_pkg::word_type buf_ff [16];
   logic [5:0]           fill_ff, fill_in;
   logic                 full_ff, full_in;
   logic [63:0]          len_ff, len_in;
   logic [63:0]          tlen_ff;
   sha256_pkg::word_type cv_ff [8];
   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type w_ff [16];
   logic [5:0]           round_ff, round_in;
   sha256_pkg::word_type dig_ff [8];
   logic [7:0]           wbyte;
   sha256_pkg::word_type t1, t2, s0, s1, wnew, wcur;

   always_comb begin
      unique case (cmd.src)
         sha256_pkg::SRC_INPUT: wbyte = in_byte;
         sha256_pkg::SRC_PAD:   wbyte = sha256_pkg::PadByte;
         sha256_pkg::SRC_ZERO:  wbyte = 8'h00;
         sha256_pkg::SRC_LEN:   wbyte = tlen_ff[{~status.len_pos, 3'b000} +: 8];
         default:               wbyte = 8'h00;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      full_in = full_ff;
      len_in  = len_ff;
      if (cmd.put) begin
         fill_in = fill_ff + 6'd1;
         full_in = (fill_ff == 6'd63);
      end
      if (cmd.count_len) len_in = len_ff + 64'd8;
      if (cmd.restart_fill) full_in = 1'b0;
      if (cmd.restart) begin
         fill_in = '0;
         full_in = 1'b0;
         len_in  = '0;
      end
   end

   // message schedule as a sliding window of sixteen words
   // taps: w[t-16]=w_ff[15], w[t-15]=w_ff[14], w[t-7]=w_ff[6], w[t-2]=w_ff[1]
   assign wcur = (round_ff < 6'd16) ? buf_ff[round_ff[3:0]] : wnew;
   assign s0 = sha256_pkg::rotr(w_ff[14], 7) ^ sha256_pkg::rotr(w_ff[14], 18)
               ^ (w_ff[14] >> 3);
   assign s1 = sha256_pkg::rotr(w_ff[1], 17) ^ sha256_pkg::rotr(w_ff[1], 19)
               ^ (w_ff[1] >> 10);
   assign wnew = w_ff[15] + s0 + w_ff[6] + s1;

   always_comb begin
      t1 = v_ff[7] + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
           ^ sha256_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + sha256_pkg::RoundConst[round_ff] + wcur;
      t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
           ^ sha256_pkg::rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign round_in = cmd.comp_start ? 6'd0 : (cmd.comp_step ? round_ff + 6'd1 : round_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         full_ff  <= 1'b0;
         len_ff   <= '0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= sha256_pkg::InitialHash[i];
      end else begin
         fill_ff  <= fill_in;
         full_ff  <= full_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         if (cmd.comp_fold) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] + v_ff[i];
         end else if (cmd.restart) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= sha256_pkg::InitialHash[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wbyte;
      if (cmd.latch_len) tlen_ff <= len_ff;
      if (cmd.comp_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[i];
      end else if (cmd.comp_step) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         // w_ff[0] newest; w_ff[15] is w[t-16] after slide
         for (int i = 15; i > 0; i--) w_ff[i] <= w_ff[i - 1];
         w_ff[0] <= wcur;
      end
      if (cmd.out_load) begin
         for (int i = 0; i < 8; i++) dig_ff[i] <= cv_ff[i];
      end else if (cmd.out_shift) begin
         for (int i = 0; i < 7; i++) dig_ff[i] <= dig_ff[i + 1];
      end
   end

   assign status.fill       = fill_ff;
   assign status.block_full = full_ff;
   assign status.last_round = (round_ff == 6'd63);
   assign status.len_pos    = fill_ff[2:0];
   assign out_word          = dig_ff[0];

endmodule

/* src/sha256_control.sv */
module sha256_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_tuser,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [2:0]                word_idx,
   input  sha256_pkg::dp_status_type status,
   output sha256_pkg::dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COMP  = 6'b000010,
      ST_FOLD  = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_LOAD  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic       closing_ff, closing_in;
   logic [2:0] idx_ff, idx_in;
   logic       acc;
   // padding and trailer tracking
   logic       padding_ff, padding_in, trailer_ff, trailer_in;
   logic       in_len_ff, in_len_in;

   assign req_tready = (state_ff == ST_IDLE) && !status.block_full;
   assign acc        = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign word_idx   = idx_ff;

   always_comb begin
      state_in   = state_ff;
      closing_in = closing_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.src    = sha256_pkg::SRC_INPUT;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.block_full) begin
               cmd.comp_start = 1'b1;
               state_in = ST_COMP;
            end else if (acc) begin
               cmd.put       = req_tuser[0];
               cmd.count_len = req_tuser[0];
               if (req_tuser[1]) begin
                  closing_in = 1'b1;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // latch the length once all input bytes are counted
            cmd.latch_len = closing_ff;
            if (status.block_full) begin
               cmd.comp_start = 1'b1;
               state_in = ST_COMP;
            end else begin
               cmd.put    = 1'b1;
               closing_in = 1'b0;
               if (closing_ff) cmd.src = sha256_pkg::SRC_PAD;
               else if (in_len_ff || status.fill == 6'(sha256_pkg::LenOffset))
                  cmd.src = sha256_pkg::SRC_LEN;
               else cmd.src = sha256_pkg::SRC_ZERO;
            end
         end
         ST_COMP: begin
            cmd.comp_step = 1'b1;
            if (status.last_round) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.comp_fold = 1'b1;
            cmd.restart   = 1'b0;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            // a trailer block ends with fill wrapped and length latched
            if (padding_ff) begin
               if (trailer_ff) begin
                  cmd.out_load = 1'b1;
                  idx_in = '0;
                  state_in = ST_OUT;
               end else state_in = ST_PAD;
            end else state_in = ST_IDLE;
            cmd.restart_fill = 1'b1;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.out_shift = 1'b1;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      padding_in = padding_ff;
      trailer_in = trailer_ff;
      in_len_in  = in_len_ff;
      if (state_ff == ST_IDLE && acc && req_tuser[1]) begin
         padding_in = 1'b1;
         trailer_in = 1'b0;
      end
      // length bytes run on once started, into the wrap
      if (state_ff == ST_PAD && cmd.put && cmd.src == sha256_pkg::SRC_LEN) begin
         in_len_in = 1'b1;
         if (status.fill == 6'd63) trailer_in = 1'b1;
      end
      if (cmd.restart) begin
         padding_in = 1'b0;
         trailer_in = 1'b0;
         in_len_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
         idx_ff     <= '0;
         padding_ff <= 1'b0;
         trailer_ff <= 1'b0;
         in_len_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         idx_ff     <= idx_in;
         padding_ff <= padding_in;
         trailer_ff <= trailer_in;
         in_len_ff  <= in_len_in;
      end
   end

endmodule

/* src/sha256_byte_stream_hasher.sv */
// SHA-256 over a byte stream. Each req transfer carries an optional byte
// (tuser[0]) and an end-of-message flag (tuser[1]); bytes fill a 64-byte
// block buffer and a full block runs 64 compression rounds, one per cycle,
// plus a start step, a fold step and a reload step, during which
// req_tready is low.
// On end of message the block pads (one byte per cycle, one or two
// compressions) and then gives eight rsp transfers, digest word 0 first,
// with the word index in tuser and tlast on word 7.
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // msg_byte
   input  logic [1:0]  req_tuser,  // byte_present, end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // digest_word
   output logic [2:0]  rsp_tuser,  // word_index
   output logic        rsp_tlast   // last_word
);

   sha256_pkg::dp_cmd_type    cmd;
   sha256_pkg::dp_status_type status;

   sha256_control u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser,
      .rsp_tready, .rsp_tvalid, .word_idx(rsp_tuser), .status, .cmd
   );

   sha256_datapath u_dp (
      .clock, .reset, .cmd, .in_byte(req_tdata), .status, .out_word(rsp_tdata)
   );

   assign rsp_tlast = (rsp_tuser == 3'd7);

endmodule

/* verif/tb_top.sv */
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       closing;
   } byte_item_t;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_t;

   byte_item_t   pending_bytes[$];
   digest_item_t digest_expected[$];
   int           error_count = 0;
   int           hold_cycles = 0;   // long receiver hold-off, counted down
   bit           sender_paused = 1'b0;

   // predictor state
   sha256_pkg::word_type hash_state[8];
   logic [7:0]  block_bytes[64];
   int          fill_level;
   logic [63:0] length_bits;

   sha256_byte_stream_hasher dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sha256_pkg::word_type rot_right(sha256_pkg::word_type x, int r);
      return (x >> r) | (x << (32 - r));
   endfunction

   function automatic void hash_restart();
      for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitialHash[i];
      fill_level  = 0;
      length_bits = '0;
   endfunction

   function automatic void compress_block();
      sha256_pkg::word_type w[64];
      sha256_pkg::word_type v[8];
      sha256_pkg::word_type t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3))
              + (rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10));
      v = hash_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundConst[i] + w[i];
         t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   function automatic void append_byte(logic [7:0] b);
      block_bytes[fill_level] = b;
      fill_level++;
      if (fill_level == sha256_pkg::BlockBytes) begin
         compress_block();
         fill_level = 0;
      end
   endfunction

   // advances the predictor by one accepted transfer, queueing digest words
   function automatic void predict_digest(byte_item_t it);
      logic [63:0] len;
      if (it.present) begin
         length_bits += 64'd8;
         append_byte(it.data);
      end
      if (it.closing) begin
         len = length_bits;
         append_byte(sha256_pkg::PadByte);
         while (fill_level != sha256_pkg::LenOffset) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(len[63-8*i -: 8]);
         for (int i = 0; i < 8; i++)
            digest_expected.push_back('{hash_state[i], 3'(i), i == 7});
         hash_restart();
      end
   endfunction

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // a message of n random bytes, end flag on the last byte or on a separate item
   function automatic void queue_message(int n, bit separate_end);
      for (int i = 0; i < n; i++)
         pending_bytes.push_back('{8'($urandom), 1'b1, !separate_end && i == n - 1});
      if (separate_end || n == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
   endfunction

   // driver: offers queued items, random gaps in between
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_digest({req_tdata, req_tuser[0], req_tuser[1]});
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || sender_paused || pending_bytes.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               byte_item_t it;
               it = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= it.data;
               req_tuser  <= {it.closing, it.present};
               send_gap   = (hold_cycles > 0) ? 0 : gap_length();
               if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
         end
      end
   end

   // monitor: checks each word against the oldest expectation, random stalls
   int stall_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_expected.size() == 0) begin
               $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               digest_item_t e;
               e = digest_expected.pop_front();
               if (e.word !== rsp_tdata || e.index !== rsp_tuser || e.last !== rsp_tlast) begin
                  $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                           $time, e.word, e.index, e.last, rsp_tdata, rsp_tuser, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_count > 0) begin
            stall_count--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_count = gap_length();
         end
      end
   end

   initial begin
      hash_restart();
      // directed: empty message, end-only items, short messages
      queue_message(0, 1'b1);
      pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
      pending_bytes.push_back('{8'h00, 1'b1, 1'b0});
      pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
      pending_bytes.push_back('{8'h55, 1'b0, 1'b1});
      queue_message(3, 1'b0);
      queue_message(1, 1'b1);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0);
      // 56 bytes held forces an extra block; a 64th byte with the end flag
      queue_message(56, 1'b1);
      queue_message(64, 1'b0);
      // receiver holds off long while the sender keeps offering
      @(posedge clock);
      hold_cycles = 600;
      queue_message(20, 1'b0);
      queue_message(5, 1'b0);
      wait (pending_bytes.size() == 0 && digest_expected.size() == 0);
      // sender pause until every digest has come
      sender_paused = 1'b1;
      wait (digest_expected.size() == 0);
      repeat (200) @(posedge clock);
      sender_paused = 1'b0;
      // random short messages; noise items between
      for (int m = 0; m < 3; m++) begin
         int n;
         n = $urandom_range(0, 10);
         if ($urandom_range(0, 2) == 0)
            pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         queue_message(n, $urandom_range(0, 1));
      end
      wait (pending_bytes.size() == 0 && !req_tvalid);
      wait (digest_expected.size() == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0 && digest_expected.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
